// ===== sv/lpim_pkg.sv =====
// ----------------------------------------------------------------------------
// lpim_pkg
// Shared types and constants for the layer pair interaction matrix.
// ----------------------------------------------------------------------------
package lpim_pkg;

   localparam int MODE_WIDTH  = 3;
   localparam int ID_WIDTH    = 32;
   localparam int INDEX_WIDTH = 5;
   localparam int MASK_WIDTH  = 32;

   localparam int DEFAULT_NUM_SLOTS = 32;
   localparam int DEFAULT_ID_BITS   = 32;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_SET_SLOT    = 3'd0,
      MODE_CONNECT     = 3'd1,
      MODE_DISCONNECT  = 3'd2,
      MODE_QUERY_IDS   = 3'd3,
      MODE_QUERY_SLOTS = 3'd4,
      MODE_LOOKUP      = 3'd5
   } mode_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]  mode;
      logic [ID_WIDTH-1:0]    first_id;
      logic [ID_WIDTH-1:0]    second_id;
      logic [INDEX_WIDTH-1:0] first_index;
      logic [INDEX_WIDTH-1:0] second_index;
   } req_item_type;

   typedef struct packed {
      logic                   interacts;
      logic                   found;
      logic [MASK_WIDTH-1:0]  layer_mask;
      logic [INDEX_WIDTH-1:0] layer_position;
   } rsp_item_type;

   // Pair matrix update command.
   typedef struct packed {
      logic write_en;
      logic write_value;
   } pair_cmd_type;

endpackage

// ===== sv/lpim_req_if.sv =====
// ----------------------------------------------------------------------------
// lpim_req_if
// Request channel: one operation item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpim_req_if;
   import lpim_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [MODE_WIDTH-1:0]  mode;
   logic [ID_WIDTH-1:0]    first_id;
   logic [ID_WIDTH-1:0]    second_id;
   logic [INDEX_WIDTH-1:0] first_index;
   logic [INDEX_WIDTH-1:0] second_index;

   modport source (output valid, mode, first_id, second_id, first_index, second_index,
                   input ready);
   modport sink   (input valid, mode, first_id, second_id, first_index, second_index,
                   output ready);
endinterface

// ===== sv/lpim_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lpim_rsp_if
// Response channel: one result item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpim_rsp_if;
   import lpim_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   interacts;
   logic                   found;
   logic [MASK_WIDTH-1:0]  layer_mask;
   logic [INDEX_WIDTH-1:0] layer_position;

   modport source (output valid, interacts, found, layer_mask, layer_position,
                   input ready);
   modport sink   (input valid, interacts, found, layer_mask, layer_position,
                   output ready);
endinterface

// ===== sv/lpim_pair_matrix.sv =====
// ----------------------------------------------------------------------------
// lpim_pair_matrix
// Symmetric slot-pair interaction bits; one-hot row/column read and update.
// ----------------------------------------------------------------------------
module lpim_pair_matrix #(
   parameter int NUM_SLOTS = lpim_pkg::DEFAULT_NUM_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [NUM_SLOTS-1:0]   sel_a,
   input  logic [NUM_SLOTS-1:0]   sel_b,
   input  lpim_pkg::pair_cmd_type cmd,
   output logic                   linked
);
   import lpim_pkg::*;

   logic [NUM_SLOTS-1:0] rows_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] rows_in [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] row_pick;

   // Read: select row of slot a, test column of slot b.
   always_comb begin
      row_pick = '0;
      for (int a = 0; a < NUM_SLOTS; a++) begin
         if (sel_a[a]) begin
            row_pick = row_pick | rows_ff[a];
         end
      end
      linked = |(row_pick & sel_b);
   end

   // Update both mirror positions of the pair.
   always_comb begin
      for (int a = 0; a < NUM_SLOTS; a++) begin
         for (int b = 0; b < NUM_SLOTS; b++) begin
            rows_in[a][b] = rows_ff[a][b];
            if (cmd.write_en && ((sel_a[a] && sel_b[b]) || (sel_b[a] && sel_a[b]))) begin
               rows_in[a][b] = cmd.write_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '{default: '0};
      end else begin
         rows_ff <= rows_in;
      end
   end

   a_write_distinct: assert property (@(posedge clock) disable iff (reset)
      cmd.write_en |-> ($onehot(sel_a) && $onehot(sel_b) && (sel_a != sel_b)))
      else $error("pair write without two distinct slots");

   a_symmetric: assert property (@(posedge clock) disable iff (reset)
      rows_ff[0][1] == rows_ff[1][0])
      else $error("pair matrix lost symmetry");

   a_diag_clear: assert property (@(posedge clock) disable iff (reset)
      rows_ff[0][0] == 1'b0)
      else $error("diagonal bit set");

endmodule

// ===== sv/layer_pair_interaction_matrix_core.sv =====
// ----------------------------------------------------------------------------
// layer_pair_interaction_matrix_core
// Layer id table plus pair interaction matrix; one operation per item.
// ----------------------------------------------------------------------------
// Result path: an accepted item passes the input register, then the result
//   register.
// Throughput: one item per cycle while the result register is drained; the id
//   compare across all slots and the pair-bit read-modify-write both complete in the execute stage.
// Reset: synchronous; clears all slot ids to zero, all pair bits, and both
//   pipeline valid flags. No clearing pass; the block is ready right away.
module layer_pair_interaction_matrix_core #(
   parameter int NUM_SLOTS = lpim_pkg::DEFAULT_NUM_SLOTS,
   parameter int ID_BITS   = lpim_pkg::DEFAULT_ID_BITS
) (
   input logic       clock,
   input logic       reset,
   lpim_req_if.sink   req_if,
   lpim_rsp_if.source rsp_if
);
   import lpim_pkg::*;

   localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   // Wide enough to hold both an index field and the slot count.
   localparam int CMP_W = (SLOT_BITS + 1 > INDEX_WIDTH) ? SLOT_BITS + 1 : INDEX_WIDTH + 1;

   // Input stage
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, s1_item_in;
   logic         s1_fire;

   // Result stage
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // Slot id table: each entry feeds its own pair of comparators.
   logic [ID_BITS-1:0] ids_ff [NUM_SLOTS];
   logic [ID_BITS-1:0] ids_in [NUM_SLOTS];

   // Execute-stage signals
   logic [ID_BITS-1:0]   key1, key2;
   logic [NUM_SLOTS-1:0] match1, match2;
   logic [NUM_SLOTS-1:0] low1, low2;
   logic [NUM_SLOTS-1:0] dec1, dec2;
   logic [NUM_SLOTS-1:0] sel_a, sel_b;
   logic [SLOT_BITS-1:0] pos1;
   logic                 found1, found2;
   logic                 range1, range2;
   logic                 linked;
   logic                 set_slot;
   pair_cmd_type         pair_cmd;

   // ---------------------------------------------------------------------
   // Handshake: input stage moves when the result register is free or
   // being drained this cycle.
   // ---------------------------------------------------------------------
   assign s1_fire      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_if.ready) begin
         s1_valid_in = req_if.valid;
         s1_item_in  = '{mode:         req_if.mode,
                         first_id:     req_if.first_id,
                         second_id:    req_if.second_id,
                         first_index:  req_if.first_index,
                         second_index: req_if.second_index};
      end
   end

   // ---------------------------------------------------------------------
   // Id lookup: compare against all slots, keep the lowest hit.
   // ---------------------------------------------------------------------
   always_comb begin
      key1 = ID_BITS'(s1_item_ff.first_id);
      key2 = ID_BITS'(s1_item_ff.second_id);
      for (int a = 0; a < NUM_SLOTS; a++) begin
         match1[a] = (ids_ff[a] == key1);
         match2[a] = (ids_ff[a] == key2);
      end
      low1   = match1 & (~match1 + NUM_SLOTS'(1));
      low2   = match2 & (~match2 + NUM_SLOTS'(1));
      found1 = |match1;
      found2 = |match2;

      pos1 = '0;
      for (int a = 0; a < NUM_SLOTS; a++) begin
         if (low1[a]) begin
            pos1 = pos1 | SLOT_BITS'(a);
         end
      end
   end

   // Slot index decode for set slot and slot query; out of range decodes
   // to all zero.
   always_comb begin
      range1 = CMP_W'(s1_item_ff.first_index)  < CMP_W'(NUM_SLOTS);
      range2 = CMP_W'(s1_item_ff.second_index) < CMP_W'(NUM_SLOTS);
      for (int a = 0; a < NUM_SLOTS; a++) begin
         dec1[a] = (CMP_W'(s1_item_ff.first_index)  == CMP_W'(a));
         dec2[a] = (CMP_W'(s1_item_ff.second_index) == CMP_W'(a));
      end
   end

   // Slot query addresses the matrix by index, every other mode by lookup.
   always_comb begin
      if (s1_item_ff.mode == MODE_QUERY_SLOTS) begin
         sel_a = dec1;
         sel_b = dec2;
      end else begin
         sel_a = low1;
         sel_b = low2;
      end
   end

   lpim_pair_matrix #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_pair_matrix (
      .clock  (clock),
      .reset  (reset),
      .sel_a  (sel_a),
      .sel_b  (sel_b),
      .cmd    (pair_cmd),
      .linked (linked)
   );

   // ---------------------------------------------------------------------
   // Operation decode and result build.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_item_in = '0;
      set_slot    = 1'b0;
      pair_cmd    = '0;
      case (s1_item_ff.mode)
         MODE_SET_SLOT: begin
            if (range1) begin
               rsp_item_in.found = 1'b1;
               set_slot          = s1_fire;
            end
         end
         MODE_CONNECT, MODE_DISCONNECT: begin
            rsp_item_in.found = found1 && found2;
            // Equal ids or the same slot leave the matrix untouched.
            if (found1 && found2 && (key1 != key2) && (low1 != low2)) begin
               pair_cmd.write_en = s1_fire;
            end
            pair_cmd.write_value = (s1_item_ff.mode == MODE_CONNECT);
         end
         MODE_QUERY_IDS: begin
            rsp_item_in.found = found1 && found2;
            if (key1 == key2) begin
               rsp_item_in.interacts = 1'b1;
            end else if (found1 && found2) begin
               rsp_item_in.interacts = (low1 == low2) || linked;
            end
         end
         MODE_QUERY_SLOTS: begin
            if (range1 && range2) begin
               rsp_item_in.found     = 1'b1;
               rsp_item_in.interacts =
                  (s1_item_ff.first_index == s1_item_ff.second_index) || linked;
            end
         end
         MODE_LOOKUP: begin
            if (found1) begin
               rsp_item_in.found          = 1'b1;
               // Slots above the mask width drop out of the mask.
               rsp_item_in.layer_mask     = MASK_WIDTH'(low1);
               rsp_item_in.layer_position = INDEX_WIDTH'(pos1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int a = 0; a < NUM_SLOTS; a++) begin
         ids_in[a] = ids_ff[a];
         if (set_slot && dec1[a]) begin
            ids_in[a] = key1;
         end
      end
   end

   // Result register: loads on execute, clears when drained.
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ids_ff       <= '{default: '0};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ids_ff       <= ids_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      if (s1_fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.interacts      = rsp_item_ff.interacts;
   assign rsp_if.found          = rsp_item_ff.found;
   assign rsp_if.layer_mask     = rsp_item_ff.layer_mask;
   assign rsp_if.layer_position = rsp_item_ff.layer_position;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid right after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_if.valid |-> req_if.ready)
      else $error("input stalled with empty result register");

   a_mask_needs_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.layer_mask != '0)) |->
         (rsp_if.found && $onehot(rsp_if.layer_mask)))
      else $error("mask without a single matched slot");

   a_position_needs_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.found) |-> (rsp_if.layer_position == '0))
      else $error("position reported without a match");

endmodule
